>>> rtl/core/mstc_pkg.sv
package mstc_pkg;

	// Character class decided by the front end; the back end resolves it against the parse phase.
	typedef enum logic [2:0] {
		CLS_DIGIT,
		CLS_LETTER,
		CLS_OPEN,
		CLS_DEL,
		CLS_INS,
		CLS_OTHER
	} cls_t;

	typedef enum logic {
		PH_MATCH,
		PH_INDEL
	} phase_t;

	typedef struct packed {
		cls_t       cls;
		logic [3:0] digit;
		logic       eos;
	} item_t;

	localparam logic [1:0] KIND_MATCH = 2'd0;
	localparam logic [1:0] KIND_INS   = 2'd1;
	localparam logic [1:0] KIND_DEL   = 2'd2;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_OPEN  = 8'h3e;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] DIGIT_MASK = 8'h0f;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;

endpackage

>>> rtl/core/mstc_front.sv
module mstc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [7:0]     char_code,
	input  logic           end_of_string,
	output logic           q_push,
	output mstc_pkg::item_t q_item,
	input  logic           q_full
);
	import mstc_pkg::*;

	logic  v_s1;
	item_t item_s1;
	item_t item_d;
	logic  accept;
	logic [7:0] masked;

	assign in_stall = v_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign q_push   = v_s1 && !q_full;
	assign q_item   = item_s1;
	assign masked   = char_code & DIGIT_MASK;

	always_comb begin
		item_d.digit = masked[3:0];
		item_d.eos   = end_of_string;
		if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
			item_d.cls = CLS_DIGIT;
		end else if (char_code >= CH_A && char_code <= CH_T) begin
			item_d.cls = CLS_LETTER;
		end else if (char_code == CH_OPEN) begin
			item_d.cls = CLS_OPEN;
		end else if (char_code == CH_PLUS) begin
			item_d.cls = CLS_DEL;
		end else if (char_code == CH_MINUS) begin
			item_d.cls = CLS_INS;
		end else begin
			item_d.cls = CLS_OTHER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (q_push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

endmodule

>>> rtl/core/mstc_queue.sv
module mstc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mstc_pkg::item_t item_in,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output mstc_pkg::item_t item_out
);
	import mstc_pkg::*;

	item_t              ent_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0]   cnt_q;

	assign full     = cnt_q == (Q_PTR_W+1)'(Q_DEPTH);
	assign valid    = cnt_q != '0;
	assign item_out = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= item_in;
		end
	end

endmodule

>>> rtl/core/mstc_back.sv
module mstc_back #(
	parameter int LENGTH_BITS = 28
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  mstc_pkg::item_t        q_item,
	output logic                   q_pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             op_kind,
	output logic [LENGTH_BITS-1:0] op_length,
	output logic                   last_op,
	output logic [LENGTH_BITS-1:0] edit_distance,
	output logic                   malformed
);
	import mstc_pkg::*;

	localparam int L = LENGTH_BITS;
	localparam logic [L-1:0] LEN_MAX = {L{1'b1}};

	typedef struct packed {
		logic [1:0]   kind;
		logic [L-1:0] len;
		logic         last;
		logic [L-1:0] edist;
		logic         mal;
	} res_t;

	phase_t       phase_q, phase_d;
	logic [L-1:0] acc_q, acc_d;
	logic [L-1:0] seg_q, seg_d;
	logic [1:0]   held_kind_q, held_kind_d;
	logic [L-1:0] held_len_q, held_len_d;
	logic         held_v_q, held_v_d;
	logic [L-1:0] dist_q, dist_d;
	logic         err_q, err_d;
	logic         fin_q, fin_d;

	res_t         slot0_q, slot1_q, slot0_d, slot1_d;
	logic [1:0]   cnt_q, cnt_d, free;
	logic         pop_out, fire, work;
	logic [1:0]   n_res;
	res_t         r0, r1;

	// shared push unit
	logic         push_en;
	logic [1:0]   push_kind;
	logic [L-1:0] push_a, push_b;
	logic [L:0]   plen;
	logic [L+1:0] merged;
	logic         push_nz, same, emit_held, take;
	logic [L-1:0] new_len;

	logic [L+3:0] acc_w, prod;
	logic [L+1:0] seg_inc;
	logic [L:0]   dist_inc, dist_add;
	logic         mal_fin;

	// push request: operation kind and length as the sum of two terms
	always_comb begin
		push_en   = 1'b0;
		push_kind = KIND_MATCH;
		push_a    = seg_q;
		push_b    = acc_q;
		if (fin_q) begin
			push_en = phase_q == PH_MATCH;
		end else begin
			case (q_item.cls)
				CLS_OPEN: begin
					push_en = phase_q == PH_MATCH;
				end
				CLS_INS, CLS_DEL: begin
					push_en   = phase_q == PH_INDEL;
					push_kind = (q_item.cls == CLS_DEL) ? KIND_DEL : KIND_INS;
					push_a    = '0;
				end
				default: begin
					push_en = 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		plen      = {1'b0, push_a} + {1'b0, push_b};
		merged    = {2'b00, held_len_q} + {1'b0, plen};
		push_nz   = plen != '0;
		same      = held_v_q && (held_kind_q == push_kind);
		take      = push_en && push_nz;
		emit_held = take && held_v_q && !same;
		if (same) begin
			new_len = (merged[L+1:L] != 2'b00) ? LEN_MAX : merged[L-1:0];
		end else begin
			new_len = plen[L] ? LEN_MAX : plen[L-1:0];
		end
	end

	// parse phase
	always_comb begin
		phase_d = phase_q;
		if (fin_q) begin
			phase_d = PH_MATCH;
		end else begin
			case (q_item.cls)
				CLS_OPEN: begin
					if (phase_q == PH_MATCH) begin
						phase_d = PH_INDEL;
					end
				end
				CLS_INS, CLS_DEL: begin
					if (phase_q == PH_INDEL) begin
						phase_d = PH_MATCH;
					end
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	// counters and held operation
	always_comb begin
		acc_w    = {4'b0000, acc_q};
		prod     = (acc_w << 3) + (acc_w << 1) + {{L{1'b0}}, q_item.digit};
		seg_inc  = {2'b00, seg_q} + {2'b00, acc_q} + (L+2)'(1);
		dist_inc = {1'b0, dist_q} + (L+1)'(1);
		dist_add = {1'b0, dist_q} + {1'b0, acc_q};

		acc_d       = acc_q;
		seg_d       = seg_q;
		held_kind_d = held_kind_q;
		held_len_d  = held_len_q;
		held_v_d    = held_v_q;
		dist_d      = dist_q;
		err_d       = err_q;
		fin_d       = fin_q;

		if (fin_q) begin
			// string done: return to the reset state
			acc_d       = '0;
			seg_d       = '0;
			held_kind_d = KIND_MATCH;
			held_len_d  = '0;
			held_v_d    = 1'b0;
			dist_d      = '0;
			err_d       = 1'b0;
			fin_d       = 1'b0;
		end else begin
			fin_d = q_item.eos;
			if (take) begin
				held_kind_d = push_kind;
				held_len_d  = new_len;
				held_v_d    = 1'b1;
			end
			case (q_item.cls)
				CLS_DIGIT: begin
					acc_d = (prod[L+3:L] != 4'b0000) ? LEN_MAX : prod[L-1:0];
				end
				CLS_LETTER: begin
					if (phase_q == PH_MATCH) begin
						seg_d  = (seg_inc[L+1:L] != 2'b00) ? LEN_MAX : seg_inc[L-1:0];
						acc_d  = '0;
						dist_d = dist_inc[L] ? LEN_MAX : dist_inc[L-1:0];
					end else begin
						err_d = 1'b1;
					end
				end
				CLS_OPEN: begin
					if (phase_q == PH_MATCH) begin
						seg_d = '0;
						acc_d = '0;
					end else begin
						err_d = 1'b1;
					end
				end
				CLS_INS, CLS_DEL: begin
					if (phase_q == PH_INDEL) begin
						dist_d = dist_add[L] ? LEN_MAX : dist_add[L-1:0];
						acc_d  = '0;
					end else begin
						err_d = 1'b1;
					end
				end
				default: begin
					err_d = 1'b1;
				end
			endcase
		end
	end

	// results of this cycle
	always_comb begin
		mal_fin = err_q || (phase_q == PH_INDEL);
		r0      = '{kind: held_kind_q, len: held_len_q, last: 1'b0, edist: '0, mal: 1'b0};
		r1      = '{kind: take ? push_kind : held_kind_q,
			len: take ? new_len : held_len_q,
			last: 1'b1, edist: dist_q, mal: mal_fin};
		if (!(held_v_q || take)) begin
			r1.kind = KIND_MATCH;
			r1.len  = '0;
		end
		if (fin_q) begin
			n_res = emit_held ? 2'd2 : 2'd1;
			if (!emit_held) begin
				r0 = r1;
			end
		end else begin
			n_res = emit_held ? 2'd1 : 2'd0;
		end
	end

	// output buffer: two slots, slot0 drives the port
	assign out_valid = cnt_q != 2'd0;
	assign pop_out   = out_valid && !out_stall;
	assign free      = 2'd2 - cnt_q + {1'b0, pop_out};
	assign work      = fin_q || q_valid;
	assign fire      = work && (n_res <= free);
	assign q_pop     = fire && !fin_q;

	assign op_kind       = slot0_q.kind;
	assign op_length     = slot0_q.len;
	assign last_op       = slot0_q.last;
	assign edit_distance = slot0_q.edist;
	assign malformed     = slot0_q.mal;

	always_comb begin
		slot0_d = slot0_q;
		slot1_d = slot1_q;
		cnt_d   = cnt_q;
		if (pop_out) begin
			slot0_d = slot1_q;
			cnt_d   = cnt_q - 2'd1;
		end
		if (fire && n_res != 2'd0) begin
			if (cnt_d == 2'd0) begin
				slot0_d = r0;
			end else begin
				slot1_d = r0;
			end
			if (n_res == 2'd2) begin
				slot1_d = r1;
			end
			cnt_d = cnt_d + n_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_MATCH;
			acc_q       <= '0;
			seg_q       <= '0;
			held_kind_q <= KIND_MATCH;
			held_len_q  <= '0;
			held_v_q    <= 1'b0;
			dist_q      <= '0;
			err_q       <= 1'b0;
			fin_q       <= 1'b0;
			cnt_q       <= 2'd0;
		end else begin
			cnt_q <= cnt_d;
			if (fire) begin
				phase_q     <= phase_d;
				acc_q       <= acc_d;
				seg_q       <= seg_d;
				held_kind_q <= held_kind_d;
				held_len_q  <= held_len_d;
				held_v_q    <= held_v_d;
				dist_q      <= dist_d;
				err_q       <= err_d;
				fin_q       <= fin_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		slot0_q <= slot0_d;
		slot1_q <= slot1_d;
	end

endmodule

>>> rtl/core/md_string_to_cigar_ops_unit.sv
// channel  | direction | handshake           | payload
// input    | in        | in_valid / in_stall  | char_code, end_of_string
// result   | out       | out_valid / out_stall| op_kind, op_length, last_op, edit_distance, malformed
//
// One character is taken per cycle unless in_stall is high; the front register and a
// two-entry queue decouple parsing. The back end executes one character per cycle while its
// output buffer has room; the final character of a string adds a back-end step to close the
// last segment and emit the final operation. A character yields at most one operation, the
// string close at most two; the two-slot output buffer keeps the back end running while a
// result waits under out_stall. Each result is registered in the output buffer before it is
// offered. Reset clears all control state.
module md_string_to_cigar_ops_unit #(
	parameter int LENGTH_BITS = 28
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             char_code,
	input  logic                   end_of_string,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             op_kind,
	output logic [LENGTH_BITS-1:0] op_length,
	output logic                   last_op,
	output logic [LENGTH_BITS-1:0] edit_distance,
	output logic                   malformed
);
	import mstc_pkg::*;

	logic  q_push, q_full, q_pop, q_valid;
	item_t q_in, q_out;

	mstc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.char_code     (char_code),
		.end_of_string (end_of_string),
		.q_push        (q_push),
		.q_item        (q_in),
		.q_full        (q_full)
	);

	mstc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.item_in  (q_in),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.item_out (q_out)
	);

	mstc_back #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (q_out),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.op_kind       (op_kind),
		.op_length     (op_length),
		.last_op       (last_op),
		.edit_distance (edit_distance),
		.malformed     (malformed)
	);

endmodule

>>> rtl/core/mstc_checker.sv
module mstc_checker #(
	parameter int LENGTH_BITS = 28
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_stall,
	input logic [7:0]             char_code,
	input logic                   end_of_string,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [1:0]             op_kind,
	input logic [LENGTH_BITS-1:0] op_length,
	input logic                   last_op,
	input logic [LENGTH_BITS-1:0] edit_distance,
	input logic                   malformed
);
	import mstc_pkg::*;

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (op_kind == KIND_MATCH || op_kind == KIND_INS || op_kind == KIND_DEL))
		else $error("illegal operation kind");

	// distance and flag only travel with the final operation
	a_tail_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_op |-> edit_distance == '0 && !malformed)
		else $error("distance or flag on non-final operation");

	// zero-length operations are dropped except the empty final marker
	a_no_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_op |-> op_length != '0)
		else $error("zero-length operation emitted");

	// an indel is never the length-zero final marker
	a_empty_final_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_op && op_length == '0 |-> op_kind == KIND_MATCH)
		else $error("empty final operation not a match");

endmodule

bind md_string_to_cigar_ops_unit mstc_checker #(.LENGTH_BITS(LENGTH_BITS)) u_chk (.*);
